// ===== sv/rpm_pkg.sv =====
// ============================================================================
// rpm_pkg: shared constants and types for the ray parity point-in-mesh block
// Default widths, configuration register codes and reset values.
// ============================================================================
package rpm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TALLY_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DET_FLOOR_W = 32;
    localparam logic [DET_FLOOR_W-1:0] DET_FLOOR_RESET = 32'd429497;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X  = 2'd0,
        CFG_ORIGIN_Y  = 2'd1,
        CFG_ORIGIN_Z  = 2'd2,
        CFG_DET_FLOOR = 2'd3
    } cfg_index_t;

endpackage

// ===== sv/rpm_ifs.sv =====
// ============================================================================
// rpm_ifs: channel interfaces of the ray parity point-in-mesh block
// Triangle input, result output and configuration write channels.
// ============================================================================

interface rpm_face_if #(
    parameter int COORD_WIDTH = rpm_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vert_a_x;
    logic signed [COORD_WIDTH-1:0] vert_a_y;
    logic signed [COORD_WIDTH-1:0] vert_a_z;
    logic signed [COORD_WIDTH-1:0] vert_b_x;
    logic signed [COORD_WIDTH-1:0] vert_b_y;
    logic signed [COORD_WIDTH-1:0] vert_b_z;
    logic signed [COORD_WIDTH-1:0] vert_c_x;
    logic signed [COORD_WIDTH-1:0] vert_c_y;
    logic signed [COORD_WIDTH-1:0] vert_c_z;
    logic                          final_face;

    modport source (
        output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z, final_face,
        input  ready
    );
    modport sink (
        input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z, final_face,
        output ready
    );
endinterface

interface rpm_result_if #(
    parameter int TALLY_WIDTH = rpm_pkg::TALLY_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   point_inside;
    logic [TALLY_WIDTH-1:0] crossing_total;

    modport source (output valid, point_inside, crossing_total, input ready);
    modport sink   (input  valid, point_inside, crossing_total, output ready);
endinterface

interface rpm_cfg_if #(
    parameter int DATA_WIDTH = rpm_pkg::DET_FLOOR_W
);
    logic                           valid;
    logic                           ready;
    logic [rpm_pkg::CFG_INDEX_W-1:0] index;
    logic [DATA_WIDTH-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

// ===== sv/rpm_front.sv =====
// ============================================================================
// rpm_front: triangle intake and configuration registers
// Holds the query point and floor, forms edge and translation vectors.
// ============================================================================
module rpm_front #(
    parameter int  COORD_WIDTH = rpm_pkg::COORD_WIDTH_DEF,
    parameter type entry_t     = logic
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rpm_face_if.sink                        face,
    rpm_cfg_if.sink                         cfg,
    output logic                            push_valid,
    input  logic                            push_ready,
    output entry_t                          push_data,
    output logic [rpm_pkg::DET_FLOOR_W-1:0] det_floor
);

    localparam int EW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0]   origin_x_reg;
    logic signed [COORD_WIDTH-1:0]   origin_y_reg;
    logic signed [COORD_WIDTH-1:0]   origin_z_reg;
    logic [rpm_pkg::DET_FLOOR_W-1:0] det_floor_reg;

    logic   valid_reg;
    entry_t entry_reg;
    entry_t entry_next;

    assign cfg.ready  = 1'b1;
    assign face.ready = !valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            det_floor_reg <= rpm_pkg::DET_FLOOR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rpm_pkg::CFG_ORIGIN_X:  origin_x_reg  <= cfg.data[COORD_WIDTH-1:0];
                rpm_pkg::CFG_ORIGIN_Y:  origin_y_reg  <= cfg.data[COORD_WIDTH-1:0];
                rpm_pkg::CFG_ORIGIN_Z:  origin_z_reg  <= cfg.data[COORD_WIDTH-1:0];
                rpm_pkg::CFG_DET_FLOOR: det_floor_reg <= cfg.data[rpm_pkg::DET_FLOOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // differences carry one extra bit so they never wrap
    always_comb
    begin
        entry_next.final_face = face.final_face;
        entry_next.e1x = EW'(face.vert_b_x) - EW'(face.vert_a_x);
        entry_next.e1y = EW'(face.vert_b_y) - EW'(face.vert_a_y);
        entry_next.e1z = EW'(face.vert_b_z) - EW'(face.vert_a_z);
        entry_next.e2x = EW'(face.vert_c_x) - EW'(face.vert_a_x);
        entry_next.e2y = EW'(face.vert_c_y) - EW'(face.vert_a_y);
        entry_next.e2z = EW'(face.vert_c_z) - EW'(face.vert_a_z);
        entry_next.tx  = EW'(origin_x_reg) - EW'(face.vert_a_x);
        entry_next.ty  = EW'(origin_y_reg) - EW'(face.vert_a_y);
        entry_next.tz  = EW'(origin_z_reg) - EW'(face.vert_a_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (face.ready)
            valid_reg <= face.valid;
    end

    always_ff @(posedge clk)
    begin
        if (face.valid && face.ready)
            entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_data  = entry_reg;
    assign det_floor  = det_floor_reg;

endmodule

// ===== sv/rpm_queue.sv =====
// ============================================================================
// rpm_queue: short queue between intake and hit test
// Register-based FIFO; lets each side stall on its own.
// ============================================================================
module rpm_queue #(
    parameter int  QUEUE_DEPTH = rpm_pkg::QUEUE_DEPTH_DEF,
    parameter type entry_t     = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  entry_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== sv/rpm_back.sv =====
// ============================================================================
// rpm_back: pipelined ray/triangle hit test and parity accumulator
// Six stages of products, sign fold and bound checks; then the tally.
// ============================================================================
module rpm_back #(
    parameter int  COORD_WIDTH = rpm_pkg::COORD_WIDTH_DEF,
    parameter int  TALLY_WIDTH = rpm_pkg::TALLY_WIDTH_DEF,
    parameter type entry_t     = logic
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  entry_t                          pop_data,
    input  logic [rpm_pkg::DET_FLOOR_W-1:0] det_floor,
    rpm_result_if.source                    result
);

    localparam int EW  = COORD_WIDTH + 1;     // edge / translation
    localparam int PW  = 2 * EW;              // one product
    localparam int DW  = PW + 1;              // det, u, v, qy, qz
    localparam int SW  = DW + 1;              // u + v
    localparam int LW  = COORD_WIDTH;         // low split of second operand
    localparam int HW  = DW - LW;             // high split
    localparam int LPW = EW + LW + 1;         // low partial product
    localparam int HPW = EW + HW;             // high partial product
    localparam int TPW = EW + DW;             // one term of t
    localparam int TW  = TPW + 2;             // t

    logic adv;

    // stage 1: raw products
    logic                 s1_valid_reg;
    logic                 s1_final_reg;
    logic signed [PW-1:0] s1_da_reg, s1_db_reg;
    logic signed [PW-1:0] s1_ua_reg, s1_ub_reg;
    logic signed [PW-1:0] s1_va_reg, s1_vb_reg;
    logic signed [PW-1:0] s1_qya_reg, s1_qyb_reg;
    logic signed [PW-1:0] s1_qza_reg, s1_qzb_reg;
    logic signed [EW-1:0] s1_e2x_reg, s1_e2y_reg, s1_e2z_reg;

    // stage 2: differences
    logic                 s2_valid_reg;
    logic                 s2_final_reg;
    logic signed [DW-1:0] s2_det_reg, s2_u_reg, s2_v_reg, s2_qy_reg, s2_qz_reg;
    logic signed [EW-1:0] s2_e2x_reg, s2_e2y_reg, s2_e2z_reg;
    logic                 s2_flip;

    // stage 3: determinant sign folded in
    logic                 s3_valid_reg;
    logic                 s3_final_reg;
    logic signed [DW-1:0] s3_det_reg, s3_u_reg, s3_v_reg, s3_qy_reg, s3_qz_reg;
    logic signed [EW-1:0] s3_e2x_reg, s3_e2y_reg, s3_e2z_reg;
    logic signed [LW:0]   s3_v_lo, s3_qy_lo, s3_qz_lo;
    logic signed [HW-1:0] s3_v_hi, s3_qy_hi, s3_qz_hi;

    // stage 4: bound checks, partial products of t
    logic                  s4_valid_reg;
    logic                  s4_final_reg;
    logic                  s4_ok_reg;
    logic signed [DW-1:0]  s4_det_reg;
    logic signed [SW-1:0]  s4_sum_reg;
    logic signed [LPW-1:0] s4_xlo_reg, s4_ylo_reg, s4_zlo_reg;
    logic signed [HPW-1:0] s4_xhi_reg, s4_yhi_reg, s4_zhi_reg;

    // stage 5: t terms, last bound check
    logic                  s5_valid_reg;
    logic                  s5_final_reg;
    logic                  s5_ok_reg;
    logic signed [TPW-1:0] s5_tx_reg, s5_ty_reg, s5_tz_reg;

    // stage 6: hit decision
    logic                  s6_valid_reg;
    logic                  s6_final_reg;
    logic                  s6_hit_reg;
    logic signed [TW-1:0]  s6_t;

    // accumulator and output
    logic                   parity_reg;
    logic [TALLY_WIDTH-1:0] tally_reg;
    logic                   parity_next;
    logic [TALLY_WIDTH-1:0] tally_next;
    logic                   hit_now;
    logic                   out_valid_reg;
    logic                   out_inside_reg;
    logic [TALLY_WIDTH-1:0] out_total_reg;

    // only a final face blocked by a full output register stalls the pipe
    assign adv       = !(s6_valid_reg && s6_final_reg && out_valid_reg && !result.ready);
    assign pop_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pop_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // T is used unfolded; every quantity built from it is linear in T,
    // so flipping the finished values equals flipping T up front
    assign s2_flip = s2_det_reg[DW-1] || (s2_det_reg == '0);

    assign s3_v_lo  = $signed({1'b0, s3_v_reg[LW-1:0]});
    assign s3_qy_lo = $signed({1'b0, s3_qy_reg[LW-1:0]});
    assign s3_qz_lo = $signed({1'b0, s3_qz_reg[LW-1:0]});
    assign s3_v_hi  = $signed(s3_v_reg[DW-1:LW]);
    assign s3_qy_hi = $signed(s3_qy_reg[DW-1:LW]);
    assign s3_qz_hi = $signed(s3_qz_reg[DW-1:LW]);

    assign s6_t = TW'(s5_tx_reg) + TW'(s5_ty_reg) + TW'(s5_tz_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_final_reg <= pop_data.final_face;
            s1_da_reg    <= pop_data.e1z * pop_data.e2y;
            s1_db_reg    <= pop_data.e1y * pop_data.e2z;
            s1_ua_reg    <= pop_data.tz  * pop_data.e2y;
            s1_ub_reg    <= pop_data.ty  * pop_data.e2z;
            s1_va_reg    <= pop_data.ty  * pop_data.e1z;
            s1_vb_reg    <= pop_data.tz  * pop_data.e1y;
            s1_qya_reg   <= pop_data.tz  * pop_data.e1x;
            s1_qyb_reg   <= pop_data.tx  * pop_data.e1z;
            s1_qza_reg   <= pop_data.tx  * pop_data.e1y;
            s1_qzb_reg   <= pop_data.ty  * pop_data.e1x;
            s1_e2x_reg   <= pop_data.e2x;
            s1_e2y_reg   <= pop_data.e2y;
            s1_e2z_reg   <= pop_data.e2z;

            s2_final_reg <= s1_final_reg;
            s2_det_reg   <= DW'(s1_da_reg)  - DW'(s1_db_reg);
            s2_u_reg     <= DW'(s1_ua_reg)  - DW'(s1_ub_reg);
            s2_v_reg     <= DW'(s1_va_reg)  - DW'(s1_vb_reg);
            s2_qy_reg    <= DW'(s1_qya_reg) - DW'(s1_qyb_reg);
            s2_qz_reg    <= DW'(s1_qza_reg) - DW'(s1_qzb_reg);
            s2_e2x_reg   <= s1_e2x_reg;
            s2_e2y_reg   <= s1_e2y_reg;
            s2_e2z_reg   <= s1_e2z_reg;

            s3_final_reg <= s2_final_reg;
            s3_det_reg   <= s2_flip ? -s2_det_reg : s2_det_reg;
            s3_u_reg     <= s2_flip ? -s2_u_reg   : s2_u_reg;
            s3_v_reg     <= s2_flip ? -s2_v_reg   : s2_v_reg;
            s3_qy_reg    <= s2_flip ? -s2_qy_reg  : s2_qy_reg;
            s3_qz_reg    <= s2_flip ? -s2_qz_reg  : s2_qz_reg;
            s3_e2x_reg   <= s2_e2x_reg;
            s3_e2y_reg   <= s2_e2y_reg;
            s3_e2z_reg   <= s2_e2z_reg;

            s4_final_reg <= s3_final_reg;
            s4_ok_reg    <= (s3_det_reg >= DW'($signed({1'b0, det_floor})))
                            && !s3_u_reg[DW-1] && (s3_det_reg >= s3_u_reg)
                            && !s3_v_reg[DW-1];
            s4_det_reg   <= s3_det_reg;
            s4_sum_reg   <= SW'(s3_u_reg) + SW'(s3_v_reg);
            s4_xlo_reg   <= s3_e2x_reg * s3_v_lo;
            s4_xhi_reg   <= s3_e2x_reg * s3_v_hi;
            s4_ylo_reg   <= s3_e2y_reg * s3_qy_lo;
            s4_yhi_reg   <= s3_e2y_reg * s3_qy_hi;
            s4_zlo_reg   <= s3_e2z_reg * s3_qz_lo;
            s4_zhi_reg   <= s3_e2z_reg * s3_qz_hi;

            s5_final_reg <= s4_final_reg;
            s5_ok_reg    <= s4_ok_reg && (SW'(s4_det_reg) >= s4_sum_reg);
            s5_tx_reg    <= (TPW'(s4_xhi_reg) <<< LW) + TPW'(s4_xlo_reg);
            s5_ty_reg    <= (TPW'(s4_yhi_reg) <<< LW) + TPW'(s4_ylo_reg);
            s5_tz_reg    <= (TPW'(s4_zhi_reg) <<< LW) + TPW'(s4_zlo_reg);

            s6_final_reg <= s5_final_reg;
            s6_hit_reg   <= s5_ok_reg && !s6_t[TW-1];
        end
    end

    // parity and saturating tally
    assign hit_now     = s6_valid_reg && s6_hit_reg;
    assign parity_next = parity_reg ^ hit_now;
    assign tally_next  = (hit_now && (tally_reg != '1)) ? tally_reg + TALLY_WIDTH'(1)
                                                        : tally_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv && s6_valid_reg)
            begin
                if (s6_final_reg)
                begin
                    parity_reg <= 1'b0;
                    tally_reg  <= '0;
                end
                else
                begin
                    parity_reg <= parity_next;
                    tally_reg  <= tally_next;
                end
            end
            if (adv && s6_valid_reg && s6_final_reg)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s6_valid_reg && s6_final_reg)
        begin
            out_inside_reg <= parity_next;
            out_total_reg  <= tally_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.point_inside   = out_inside_reg;
    assign result.crossing_total = out_total_reg;

    // parity tracks the tally exactly until the tally saturates
    a_parity_matches_tally: assert property (@(posedge clk) disable iff (!rst_n)
        (tally_reg != '1) |-> (parity_reg == tally_reg[0]))
        else $error("parity out of step with tally");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s6_valid_reg && s6_final_reg) |=> (tally_reg == '0 && !parity_reg))
        else $error("state not cleared after final face");

    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s6_valid_reg && s6_final_reg) |=> out_valid_reg)
        else $error("final face produced no result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s1_valid_reg) && $stable(s6_valid_reg) && $stable(tally_reg)))
        else $error("pipeline moved during stall");

endmodule

// ===== sv/ray_parity_point_in_mesh_core.sv =====
// ============================================================================
// ray_parity_point_in_mesh_core: point-in-closed-mesh test by ray parity
// Division-free ray/triangle hit test along +x with a saturating tally.
// ============================================================================
// Usage:
//   cfg    - register writes: 0..2 query point x/y/z (signed Q16.16),
//            3 minimum |det| (unsigned Q0.32). Always ready; write only
//            while no face is in flight.
//   face   - one beat per triangle: vertices A, B, C and final_face.
//   result - one beat per mesh, after the beat marked final_face:
//            point_inside (odd crossing count) and crossing_total.
// Throughput: one triangle per cycle unless stalled, set by the hit-test
//   pipeline (ten products in stage 1, six partial products in stage 4).
// Path: a final face shows on result after the intake register, the queue,
//   six hit-test stages and the output register.
// Reset: query point 0, floor 429497 (0.0001), tally and parity cleared,
//   queue and pipeline empty.
// Stall: a result waiting on result.ready blocks the pipe only when the next
//   final face reaches the accumulator; the queue then fills and face.ready
//   drops. Other faces keep flowing while the result waits.
// ============================================================================
module ray_parity_point_in_mesh_core #(
    parameter int COORD_WIDTH = rpm_pkg::COORD_WIDTH_DEF,
    parameter int TALLY_WIDTH = rpm_pkg::TALLY_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rpm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rpm_face_if.sink     face,
    rpm_result_if.source result,
    rpm_cfg_if.sink      cfg
);

    // edge vectors E1 = B - A, E2 = C - A and translation T = origin - A
    typedef struct packed {
        logic                        final_face;
        logic signed [COORD_WIDTH:0] e1x;
        logic signed [COORD_WIDTH:0] e1y;
        logic signed [COORD_WIDTH:0] e1z;
        logic signed [COORD_WIDTH:0] e2x;
        logic signed [COORD_WIDTH:0] e2y;
        logic signed [COORD_WIDTH:0] e2z;
        logic signed [COORD_WIDTH:0] tx;
        logic signed [COORD_WIDTH:0] ty;
        logic signed [COORD_WIDTH:0] tz;
    } face_entry_t;

    logic                            push_valid;
    logic                            push_ready;
    face_entry_t                     push_data;
    logic                            pop_valid;
    logic                            pop_ready;
    face_entry_t                     pop_data;
    logic [rpm_pkg::DET_FLOOR_W-1:0] det_floor;

    // intake: config registers and vector setup
    rpm_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .entry_t     (face_entry_t)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .face       (face),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .det_floor  (det_floor)
    );

    // decouples intake from the hit-test pipeline
    rpm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .entry_t     (face_entry_t)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    // hit test, parity accumulator and result register
    rpm_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .TALLY_WIDTH (TALLY_WIDTH),
        .entry_t     (face_entry_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .det_floor (det_floor),
        .result    (result)
    );

endmodule
